// ===== hdl/tts_pkg.sv =====
// tts_pkg: shared types and codes for the text terminal scrollback unit
// holds command and result codes, character constants, the sequencer state
// type and the control/status structs between sequencer and datapath
package tts_pkg;

    // input command codes
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // result kind codes
    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_NEWLINE = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;
    localparam logic [1:0] KIND_CLEARED = 2'd3;

    // character codes
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_TILDE = 8'd126;
    localparam logic [7:0] CHAR_DOT   = 8'd46;

    // spaces written for one tab
    localparam logic [2:0] TAB_SPACES = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUT,
        ST_NEWLINE,
        ST_CLEAR,
        ST_RD_SLOT,
        ST_RD_MEM,
        ST_RD_DATA
    } state_t;

    // one step request from the sequencer
    typedef struct packed {
        logic load_in;
        logic newline;
        logic put;
        logic clear;
        logic rd_slot;
        logic rd_mem;
        logic rd_out;
        logic last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic line_full;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hdl/tts_ctrl.sv =====
// tts_ctrl: sequencer of the text terminal scrollback unit
// decodes each accepted word into datapath steps; uses tts_pkg
module tts_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             command,
    input  logic [7:0]             char_code,
    input  tts_pkg::dp_status_t    status,
    output tts_pkg::ctrl_cmd_t     cmd
);

    tts_pkg::state_t state_reg;
    tts_pkg::state_t state_next;
    logic [2:0]      cnt_reg;
    logic [2:0]      cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tts_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            tts_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (command)
                        tts_pkg::CMD_PUT:
                        begin
                            priority if (char_code == tts_pkg::CHAR_CR)
                                state_next = tts_pkg::ST_IDLE;
                            else if (char_code == tts_pkg::CHAR_LF)
                                state_next = tts_pkg::ST_NEWLINE;
                            else if (char_code == tts_pkg::CHAR_TAB)
                            begin
                                state_next = tts_pkg::ST_PUT;
                                cnt_next   = tts_pkg::TAB_SPACES;
                            end
                            else
                            begin
                                state_next = tts_pkg::ST_PUT;
                                cnt_next   = 3'd1;
                            end
                        end
                        tts_pkg::CMD_CLEAR: state_next = tts_pkg::ST_CLEAR;
                        tts_pkg::CMD_READ:  state_next = tts_pkg::ST_RD_SLOT;
                        tts_pkg::CMD_NONE:  state_next = tts_pkg::ST_IDLE;
                        default:            state_next = tts_pkg::ST_IDLE;
                    endcase
                end
            end
            tts_pkg::ST_PUT:
            begin
                if (status.out_free && !status.line_full)
                begin
                    cnt_next = cnt_reg - 3'd1;
                    if (cnt_reg == 3'd1)
                        state_next = tts_pkg::ST_IDLE;
                end
            end
            tts_pkg::ST_NEWLINE,
            tts_pkg::ST_CLEAR,
            tts_pkg::ST_RD_DATA:
            begin
                if (status.out_free)
                    state_next = tts_pkg::ST_IDLE;
            end
            tts_pkg::ST_RD_SLOT: state_next = tts_pkg::ST_RD_MEM;
            tts_pkg::ST_RD_MEM:  state_next = tts_pkg::ST_RD_DATA;
            default:             state_next = tts_pkg::ST_IDLE;
        endcase
    end

    // step requests
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            tts_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            tts_pkg::ST_PUT:
            begin
                if (status.out_free)
                begin
                    if (status.line_full)
                        cmd.newline = 1'b1;
                    else
                    begin
                        cmd.put  = 1'b1;
                        cmd.last = (cnt_reg == 3'd1);
                    end
                end
            end
            tts_pkg::ST_NEWLINE:
            begin
                cmd.newline = status.out_free;
                cmd.last    = 1'b1;
            end
            tts_pkg::ST_CLEAR:
            begin
                cmd.clear = status.out_free;
                cmd.last  = 1'b1;
            end
            tts_pkg::ST_RD_SLOT: cmd.rd_slot = 1'b1;
            tts_pkg::ST_RD_MEM:  cmd.rd_mem  = 1'b1;
            tts_pkg::ST_RD_DATA:
            begin
                cmd.rd_out = status.out_free;
                cmd.last   = 1'b1;
            end
            default: cmd = '0;
        endcase
    end

endmodule

// ===== hdl/tts_datapath.sv =====
// tts_datapath: line ring state, cell and line-length stores, result register
// performs the steps requested by tts_ctrl; uses tts_pkg
module tts_datapath #(
    parameter int LINES         = 100,
    parameter int COLUMNS       = 26,
    parameter int VISIBLE_LINES = 15
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tts_pkg::ctrl_cmd_t    cmd,
    output tts_pkg::dp_status_t   status,
    input  logic [7:0]            char_code,
    input  logic [6:0]            read_row,
    input  logic [4:0]            read_col,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            kind,
    output logic [6:0]            row,
    output logic [4:0]            col,
    output logic [6:0]            char_out,
    output logic [6:0]            line_count,
    output logic [6:0]            view_start,
    output logic                  dropped_oldest,
    output logic                  last
);

    localparam int SW    = $clog2(LINES);
    localparam int LW    = $clog2(LINES + 1);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int CELLS = LINES * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = ((LW > 7) ? LW : 7) + 1;
    localparam int PW    = ((SW > 7) ? SW : 7) + 1;
    localparam int RW    = (CW > 5) ? CW : 5;

    localparam logic [LW-1:0] LINES_L = LW'(LINES);
    localparam logic [XW-1:0] LINES_X = XW'(LINES);
    localparam logic [PW-1:0] LINES_P = PW'(LINES);
    localparam logic [XW-1:0] VIS_X   = XW'(VISIBLE_LINES);
    localparam logic [CW-1:0] COLS_C  = CW'(COLUMNS);
    localparam logic [SW-1:0] SLOT_MAX = SW'(LINES - 1);

    // ring state
    logic [LW-1:0] total_reg,    total_next;
    logic [SW-1:0] oldest_reg,   oldest_next;
    logic [SW-1:0] cur_slot_reg, cur_slot_next;
    logic [CW-1:0] cursor_reg,   cursor_next;
    logic [LW-1:0] view_reg,     view_next;

    // latched input word
    logic [6:0]    char_reg;
    logic [6:0]    rrow_reg;
    logic [4:0]    rcol_reg;
    logic [6:0]    char_map;

    // read path
    logic [SW-1:0] slot_reg;
    logic          row_ok_reg;
    logic          row_cur_reg;
    logic [6:0]    cell_rd_reg;
    logic [CW-1:0] len_rd_reg;
    logic [PW-1:0] slot_sum;
    logic [CW-1:0] rd_len;
    logic [6:0]    rd_char;

    // stores
    logic [6:0]    cell_mem [CELLS];
    logic [CW-1:0] len_mem  [LINES];
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    // new line arithmetic
    logic [LW-1:0] nl_total;
    logic          nl_drop;
    logic [XW-1:0] nl_max_view;
    logic [LW-1:0] nl_view;
    logic [SW-1:0] slot_inc;

    // result register
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    kind_reg,  kind_next;
    logic [6:0]    row_reg,   row_next;
    logic [4:0]    col_reg,   col_next;
    logic [6:0]    chr_reg,   chr_next;
    logic [6:0]    count_reg, count_next;
    logic [6:0]    vstart_reg, vstart_next;
    logic          drop_reg,  drop_next;
    logic          last_reg,  last_next;
    logic          emit;

    assign status.line_full = (cursor_reg >= COLS_C);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign emit = cmd.put || cmd.newline || cmd.clear || cmd.rd_out;

    // tab becomes a space, anything outside the printable range a dot
    always_comb
    begin
        priority if (char_code == tts_pkg::CHAR_TAB)
            char_map = 7'(tts_pkg::CHAR_SPACE);
        else if (char_code < tts_pkg::CHAR_SPACE || char_code > tts_pkg::CHAR_TILDE)
            char_map = 7'(tts_pkg::CHAR_DOT);
        else
            char_map = 7'(char_code);
    end

    // new line: grow or drop the oldest, then follow the bottom when near it
    always_comb
    begin
        nl_drop  = (total_reg == LINES_L);
        nl_total = nl_drop ? total_reg : total_reg + LW'(1);
        if (XW'(nl_total) > VIS_X)
            nl_max_view = XW'(nl_total) - VIS_X;
        else
            nl_max_view = '0;
        if (XW'(view_reg) + XW'(1) >= nl_max_view)
            nl_view = LW'(nl_max_view);
        else
            nl_view = view_reg;
        slot_inc = (cur_slot_reg == SLOT_MAX) ? '0 : cur_slot_reg + SW'(1);
    end

    assign wr_addr  = AW'(AW'(cur_slot_reg) * AW'(COLUMNS)) + AW'(cursor_reg);
    assign rd_addr  = AW'(AW'(slot_reg) * AW'(COLUMNS)) + AW'(rcol_reg);
    assign slot_sum = PW'(oldest_reg) + PW'(rrow_reg);

    // the current line's length is the cursor; finished lines come from the store
    assign rd_len  = row_cur_reg ? cursor_reg : len_rd_reg;
    assign rd_char = (row_ok_reg && RW'(rcol_reg) < RW'(rd_len)) ? cell_rd_reg : '0;

    // ring state update
    always_comb
    begin
        total_next    = total_reg;
        oldest_next   = oldest_reg;
        cur_slot_next = cur_slot_reg;
        cursor_next   = cursor_reg;
        view_next     = view_reg;
        priority if (cmd.clear)
        begin
            total_next    = LW'(1);
            oldest_next   = '0;
            cur_slot_next = '0;
            cursor_next   = '0;
            view_next     = '0;
        end
        else if (cmd.newline)
        begin
            total_next    = nl_total;
            cur_slot_next = slot_inc;
            cursor_next   = '0;
            view_next     = nl_view;
            if (nl_drop)
                oldest_next = (oldest_reg == SLOT_MAX) ? '0 : oldest_reg + SW'(1);
        end
        else if (cmd.put)
        begin
            cursor_next = cursor_reg + CW'(1);
        end
        else
        begin
            cursor_next = cursor_reg;
        end
    end

    // result word
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        chr_next       = chr_reg;
        count_next     = count_reg;
        vstart_next    = vstart_reg;
        drop_next      = drop_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            last_next      = cmd.last;
            drop_next      = 1'b0;
            col_next       = '0;
            chr_next       = '0;
            count_next     = 7'(total_reg);
            vstart_next    = 7'(view_reg);
            row_next       = 7'(total_reg - LW'(1));
            priority if (cmd.clear)
            begin
                kind_next   = tts_pkg::KIND_CLEARED;
                row_next    = '0;
                count_next  = 7'd1;
                vstart_next = '0;
            end
            else if (cmd.newline)
            begin
                kind_next   = tts_pkg::KIND_NEWLINE;
                row_next    = 7'(nl_total - LW'(1));
                count_next  = 7'(nl_total);
                vstart_next = 7'(nl_view);
                drop_next   = nl_drop;
            end
            else if (cmd.put)
            begin
                kind_next = tts_pkg::KIND_WRITE;
                col_next  = 5'(cursor_reg);
                chr_next  = char_reg;
            end
            else
            begin
                kind_next = tts_pkg::KIND_READ;
                row_next  = rrow_reg;
                col_next  = rcol_reg;
                chr_next  = rd_char;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= LW'(1);
            oldest_reg    <= '0;
            cur_slot_reg  <= '0;
            cursor_reg    <= '0;
            view_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            oldest_reg    <= oldest_next;
            cur_slot_reg  <= cur_slot_next;
            cursor_reg    <= cursor_next;
            view_reg      <= view_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        chr_reg    <= chr_next;
        count_reg  <= count_next;
        vstart_reg <= vstart_next;
        drop_reg   <= drop_next;
        last_reg   <= last_next;
        if (cmd.load_in)
        begin
            char_reg <= char_map;
            rrow_reg <= read_row;
            rcol_reg <= read_col;
        end
        if (cmd.rd_slot)
        begin
            slot_reg    <= (slot_sum >= LINES_P) ? SW'(slot_sum - LINES_P) : SW'(slot_sum);
            row_ok_reg  <= (XW'(rrow_reg) < XW'(total_reg));
            row_cur_reg <= (XW'(rrow_reg) == XW'(total_reg) - XW'(1));
        end
    end

    // cell store
    always_ff @(posedge clk)
    begin
        if (cmd.put)
            cell_mem[wr_addr] <= char_reg;
        if (cmd.rd_mem)
            cell_rd_reg <= cell_mem[rd_addr];
    end

    // line length store, written as each line is closed
    always_ff @(posedge clk)
    begin
        if (cmd.newline)
            len_mem[cur_slot_reg] <= cursor_reg;
        if (cmd.rd_mem)
            len_rd_reg <= len_mem[slot_reg];
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign row            = row_reg;
    assign col            = col_reg;
    assign char_out       = chr_reg;
    assign line_count     = count_reg;
    assign view_start     = vstart_reg;
    assign dropped_oldest = drop_reg;
    assign last           = last_reg;

`ifndef SYNTHESIS
    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg >= LW'(1) && total_reg <= LINES_L)
        else $error("line total out of range");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= COLS_C)
        else $error("cursor past line end");

    a_view_bound: assert property (@(posedge clk) disable iff (!rst_n)
        view_reg == '0 || XW'(view_reg) + VIS_X <= XW'(total_reg))
        else $error("view past bottom");

    a_cur_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (XW'(oldest_reg) + XW'(total_reg) - XW'(1) == XW'(cur_slot_reg))
        || (XW'(oldest_reg) + XW'(total_reg) - XW'(1) == XW'(cur_slot_reg) + LINES_X))
        else $error("current slot does not match ring");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || out_ready))
        else $error("result overwrites untaken word");
`endif

endmodule

// ===== hdl/text_terminal_scrollback_unit.sv =====
// text_terminal_scrollback_unit: top level of the scrollback text store
// joins the tts_ctrl sequencer and tts_datapath; uses tts_pkg
//
//  channel | handshake            | word
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | command, char_code, read_row, read_col
//  out     | out_valid / out_ready| kind, row, col, char_out, line_count,
//          |                      | view_start, dropped_oldest, last
//
// steps: plain character, newline, clear: accept, then one store step;
//   tab: accept, then one step per space; each wrap to a new line adds a newline step; read: accept, slot add,
//   store read, result; carriage return and command 3: accept only
// the single write port of the cell store sets one cell per cycle while the out word is free
// reset: the cell and line-length stores are not cleared; a line's length
//   is written when the line closes and the open line uses the cursor
// stalls: each step that makes a result waits while the out word is untaken;
//   a new in word is taken while the final out word still waits
module text_terminal_scrollback_unit #(
    parameter int LINES         = 100,
    parameter int COLUMNS       = 26,
    parameter int VISIBLE_LINES = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [7:0]  char_code,
    input  logic [6:0]  read_row,
    input  logic [4:0]  read_col,
    // result words
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [6:0]  row,
    output logic [4:0]  col,
    output logic [6:0]  char_out,
    output logic [6:0]  line_count,
    output logic [6:0]  view_start,
    output logic        dropped_oldest,
    output logic        last
);

    // step requests and datapath status
    tts_pkg::ctrl_cmd_t  cmd;
    tts_pkg::dp_status_t status;

    // sequencer: decodes the command and walks the steps of one word
    tts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .char_code (char_code),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: ring pointers, cursor, view, stores and the out register
    tts_datapath #(
        .LINES         (LINES),
        .COLUMNS       (COLUMNS),
        .VISIBLE_LINES (VISIBLE_LINES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .char_code      (char_code),
        .read_row       (read_row),
        .read_col       (read_col),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .row            (row),
        .col            (col),
        .char_out       (char_out),
        .line_count     (line_count),
        .view_start     (view_start),
        .dropped_oldest (dropped_oldest),
        .last           (last)
    );

endmodule

// ===== bench/text_terminal_scrollback_unit_tb.sv =====
// text_terminal_scrollback_unit_tb: self-checking bench for the scrollback text store
// drives character, clear and read words, predicts every result word in step with
// the block and checks each one field by field; depends on tts_pkg and the top level
module text_terminal_scrollback_unit_tb;

    // geometry of the store under test, the block's default parameters
    localparam int LINES         = 100;
    localparam int COLUMNS       = 26;
    localparam int VISIBLE_LINES = 15;

    // run limits: the cap sits far above the slowest legal run
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 24;
    localparam int MAX_PER_WORD = 5;

    // one result word as the block gives it
    typedef struct {
        logic [1:0] kind;
        logic [6:0] row;
        logic [4:0] col;
        logic [6:0] char_out;
        logic [6:0] line_count;
        logic [6:0] view_start;
        logic       dropped_oldest;
        logic       last;
    } terminal_word_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] command;
    logic [7:0] char_code;
    logic [6:0] read_row;
    logic [4:0] read_col;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] kind;
    logic [6:0] row;
    logic [4:0] col;
    logic [6:0] char_out;
    logic [6:0] line_count;
    logic [6:0] view_start;
    logic       dropped_oldest;
    logic       last;

    // shadow copy of the terminal: cells, per-slot lengths and the ring pointers
    logic [6:0] shadow_cells [LINES*COLUMNS];
    int         shadow_length [LINES];
    int         shadow_lines;
    int         shadow_oldest;
    int         shadow_cursor;
    int         shadow_view;

    // words caused by the input word being predicted, then queued in order
    terminal_word_t staged_words [MAX_PER_WORD];
    int             staged_count;
    terminal_word_t pending_terminal_words [$];

    int  fail_count;
    int  cycle_count;
    bit  gaps_on;
    int  hold_off_left;
    int  ready_stall_left;

    text_terminal_scrollback_unit #(
        .LINES        (LINES),
        .COLUMNS      (COLUMNS),
        .VISIBLE_LINES(VISIBLE_LINES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .char_code     (char_code),
        .read_row      (read_row),
        .read_col      (read_col),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .row           (row),
        .col           (col),
        .char_out      (char_out),
        .line_count    (line_count),
        .view_start    (view_start),
        .dropped_oldest(dropped_oldest),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // idle length for either side: mostly none or short, now and then long
    function automatic int idle_gap();
        int pick;
        if (!gaps_on)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // terminal prediction
    // ------------------------------------------------------------------

    function automatic int slot_of_line(input int logical);
        return (shadow_oldest + logical) % LINES;
    endfunction

    // every result word carries the line count and view as they stand now
    task automatic stage_word(input logic [1:0] word_kind, input int at_row, input int at_col,
                              input int ch, input logic dropped);
        terminal_word_t w;
        w.kind           = word_kind;
        w.row            = 7'(at_row);
        w.col            = 5'(at_col);
        w.char_out       = 7'(ch);
        w.line_count     = 7'(shadow_lines);
        w.view_start     = 7'(shadow_view);
        w.dropped_oldest = dropped;
        w.last           = 1'b0;
        staged_words[staged_count] = w;
        staged_count++;
    endtask

    // open an empty line at the bottom, dropping the oldest once the ring is full
    task automatic open_line();
        int   bottom_view;
        logic dropped;
        dropped       = 1'b0;
        shadow_cursor = 0;
        if (shadow_lines < LINES)
        begin
            shadow_lines++;
            shadow_length[slot_of_line(shadow_lines - 1)] = 0;
        end
        else
        begin
            shadow_length[shadow_oldest] = 0;
            shadow_oldest = (shadow_oldest + 1) % LINES;
            dropped = 1'b1;
        end
        // the view sticks to the bottom when it was at most one row above it
        bottom_view = shadow_lines - VISIBLE_LINES;
        if (bottom_view < 0)
            bottom_view = 0;
        if (shadow_view >= bottom_view - 1)
            shadow_view = bottom_view;
        stage_word(tts_pkg::KIND_NEWLINE, shadow_lines - 1, 0, 0, dropped);
    endtask

    // write one cell at the cursor, wrapping first when the line is full
    task automatic write_cell(input int ch);
        int slot;
        if (shadow_cursor >= COLUMNS)
            open_line();
        slot = slot_of_line(shadow_lines - 1);
        shadow_cells[slot*COLUMNS + shadow_cursor] = 7'(ch);
        stage_word(tts_pkg::KIND_WRITE, shadow_lines - 1, shadow_cursor, ch, 1'b0);
        shadow_cursor++;
        shadow_length[slot] = shadow_cursor;
    endtask

    // work out the result words of one input word and queue them
    task automatic compute_terminal_words(input logic [1:0] cmd, input logic [7:0] ch,
                                          input logic [6:0] rd_row, input logic [4:0] rd_col);
        int             slot;
        int             cell_value;
        terminal_word_t w;
        staged_count = 0;
        case (cmd)
            tts_pkg::CMD_PUT:
            begin
                if (ch == tts_pkg::CHAR_CR)
                begin
                    // carriage return leaves no trace
                end
                else if (ch == tts_pkg::CHAR_LF)
                    open_line();
                else if (ch == tts_pkg::CHAR_TAB)
                begin
                    for (int i = 0; i < tts_pkg::TAB_SPACES; i++)
                        write_cell(tts_pkg::CHAR_SPACE);
                end
                else if (ch < tts_pkg::CHAR_SPACE || ch > tts_pkg::CHAR_TILDE)
                    write_cell(tts_pkg::CHAR_DOT);
                else
                    write_cell(ch);
            end
            tts_pkg::CMD_CLEAR:
            begin
                shadow_lines     = 1;
                shadow_oldest    = 0;
                shadow_cursor    = 0;
                shadow_view      = 0;
                shadow_length[0] = 0;
                stage_word(tts_pkg::KIND_CLEARED, 0, 0, 0, 1'b0);
            end
            tts_pkg::CMD_READ:
            begin
                // rows past the held lines and columns past the line end read empty
                cell_value = 0;
                if (rd_row < shadow_lines)
                begin
                    slot = slot_of_line(rd_row);
                    if (rd_col < shadow_length[slot] && rd_col < COLUMNS)
                        cell_value = shadow_cells[slot*COLUMNS + rd_col];
                end
                stage_word(tts_pkg::KIND_READ, rd_row, rd_col, cell_value, 1'b0);
            end
            default:
            begin
                // unused command code is dropped silently
            end
        endcase
        if (staged_count > 0)
        begin
            w = staged_words[staged_count - 1];
            w.last = 1'b1;
            staged_words[staged_count - 1] = w;
        end
        for (int i = 0; i < staged_count; i++)
            pending_terminal_words.push_back(staged_words[i]);
    endtask

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // offer one word at a falling edge and hold it until the block takes it;
    // valid stays high across back-to-back words so it is never dropped and
    // raised in the same step
    task automatic send_word(input logic [1:0] cmd, input logic [7:0] ch,
                             input logic [6:0] rd_row, input logic [4:0] rd_col);
        int gap;
        gap = idle_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        char_code <= ch;
        read_row  <= rd_row;
        read_col  <= rd_col;
        // nothing of this word can come out before it is taken
        compute_terminal_words(cmd, ch, rd_row, rd_col);
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // the read fields ride along as noise on a character word
    task automatic put_char(input logic [7:0] ch);
        send_word(tts_pkg::CMD_PUT, ch, 7'($urandom), 5'($urandom));
    endtask

    task automatic read_cell(input int at_row, input int at_col);
        send_word(tts_pkg::CMD_READ, 8'($urandom), 7'(at_row), 5'(at_col));
    endtask

    task automatic clear_store();
        send_word(tts_pkg::CMD_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom));
    endtask

    // a printable character or any byte at all, half and half
    function automatic logic [7:0] random_char();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(tts_pkg::CHAR_SPACE, tts_pkg::CHAR_TILDE));
        return 8'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // byte extremes, non-printables, carriage return, the unused command and
    // reads inside, past the end of, and below the held lines; no idling here
    task automatic test_character_mapping();
        gaps_on = 1'b0;
        put_char(8'h41);
        put_char(tts_pkg::CHAR_SPACE);
        put_char(tts_pkg::CHAR_TILDE);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h7F);
        put_char(8'h80);
        put_char(8'h1F);
        put_char(tts_pkg::CHAR_CR);
        send_word(tts_pkg::CMD_NONE, 8'($urandom), 7'($urandom), 5'($urandom));
        read_cell(0, 0);
        read_cell(0, 6);
        read_cell(0, 7);
        read_cell(99, 25);
        put_char(tts_pkg::CHAR_LF);
        read_cell(1, 0);
        put_char(tts_pkg::CHAR_TAB);
        read_cell(1, 3);
        gaps_on = 1'b1;
    endtask

    // a tab meeting a full line wraps on its first space; a plain character
    // meeting a full line wraps too
    task automatic test_line_wrap();
        clear_store();
        repeat (6) put_char(tts_pkg::CHAR_TAB);
        put_char(8'h78);
        put_char(8'h79);
        put_char(tts_pkg::CHAR_TAB);
        repeat (5) put_char(tts_pkg::CHAR_TAB);
        put_char(8'h2A);
        put_char(8'h5B);
        put_char(8'h3F);
        read_cell(0, 25);
        read_cell(1, 25);
        read_cell(2, 0);
    endtask

    // mostly new lines so the ring fills, drops its oldest lines and the view
    // keeps following the bottom; characters and reads are mixed in
    task automatic test_scrollback_ring();
        int line_breaks;
        int pick;
        line_breaks = 0;
        clear_store();
        while (line_breaks < LINES + 2)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 94)
            begin
                put_char(tts_pkg::CHAR_LF);
                line_breaks++;
            end
            else if (pick < 97)
                put_char(random_char());
            else
                read_cell($urandom_range(0, LINES - 1), $urandom_range(0, COLUMNS - 1));
        end
        read_cell(0, 0);
        read_cell(LINES - 1, 0);
    endtask

    // the receiver stops for a long stretch while words keep coming, so the
    // result side backs up and the block has to stall its input
    task automatic test_output_backpressure();
        gaps_on = 1'b0;
        hold_off_left = 150;
        repeat (4) put_char(random_char());
        put_char(tts_pkg::CHAR_TAB);
        read_cell(shadow_lines - 1, 0);
        put_char(tts_pkg::CHAR_LF);
        repeat (4) put_char(random_char());
        put_char(tts_pkg::CHAR_TAB);
        gaps_on = 1'b1;
    endtask

    // everything mixed: characters, line breaks, tabs, reads, clears and noise
    task automatic test_random_traffic();
        int pick;
        repeat (10)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 42)
                put_char(random_char());
            else if (pick < 56)
                put_char(tts_pkg::CHAR_LF);
            else if (pick < 64)
                put_char(tts_pkg::CHAR_TAB);
            else if (pick < 70)
                read_cell($urandom_range(0, shadow_lines), $urandom_range(0, COLUMNS - 1));
            else if (pick < 82)
                read_cell($urandom_range(0, LINES - 1), $urandom_range(0, COLUMNS - 1));
            else if (pick < 87)
                put_char(tts_pkg::CHAR_CR);
            else if (pick < 91)
                send_word(tts_pkg::CMD_NONE, 8'($urandom), 7'($urandom), 5'($urandom));
            else if (pick < 94)
                clear_store();
            else
                put_char(8'($urandom_range(0, 31)));
        end
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // random ready with a separate long hold-off counted here when asked
    initial
    begin
        out_ready = 1'b0;
        ready_stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                out_ready <= 1'b0;
                hold_off_left--;
            end
            else if (ready_stall_left > 0)
            begin
                out_ready <= 1'b0;
                ready_stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    ready_stall_left = idle_gap();
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // every taken result word is matched against the oldest prediction
    always @(posedge clk)
    begin
        terminal_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_terminal_words.size() == 0)
            begin
                $display("%0t: result word with none predicted: expected nothing, %s %0d %0d %0d %0d",
                         $time, "actual kind row col char", kind, row, col, char_out);
                fail_count++;
            end
            else
            begin
                want = pending_terminal_words.pop_front();
                check_field("kind", want.kind, kind);
                check_field("row", want.row, row);
                check_field("col", want.col, col);
                check_field("char_out", want.char_out, char_out);
                check_field("line_count", want.line_count, line_count);
                check_field("view_start", want.view_start, view_start);
                check_field("dropped_oldest", want.dropped_oldest, dropped_oldest);
                check_field("last", want.last, last);
            end
        end
    end

    // watchdog on the whole run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run stopped after %0d cycles", $time, cycle_count);
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        command       = tts_pkg::CMD_NONE;
        char_code     = 8'h00;
        read_row      = 7'd0;
        read_col      = 5'd0;
        fail_count    = 0;
        gaps_on       = 1'b1;
        hold_off_left = 0;

        // shadow state after reset: one empty line, view at the top
        shadow_lines     = 1;
        shadow_oldest    = 0;
        shadow_cursor    = 0;
        shadow_view      = 0;
        shadow_length[0] = 0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_character_mapping();
        test_line_wrap();
        test_scrollback_ring();
        test_output_backpressure();
        test_random_traffic();

        @(negedge clk);
        in_valid <= 1'b0;

        // let every predicted word come out, then watch for strays
        while (pending_terminal_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_terminal_words.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
